FILE: src/crlfla_pkg.sv
// ----------------------------------------------------------------------------
// crlfla_pkg
// Shared constants, types and helpers for the CR LF line assembler.
// ----------------------------------------------------------------------------
package crlfla_pkg;

  // Sizing
  localparam int BUF_BYTES  = 256;
  localparam int LINE_SLOTS = 8;

  localparam int BUF_AW     = $clog2(BUF_BYTES);
  localparam int BANK_DEPTH = (BUF_BYTES + 1) / 2;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);
  localparam int SLOT_AW    = $clog2(LINE_SLOTS);
  localparam int COUNT_W    = $clog2(LINE_SLOTS + 1);

  // Fixed field widths
  localparam int BYTE_W   = 8;
  localparam int OFFS_W   = 8;
  localparam int PEND_W   = 4;
  localparam int CTR_W    = 16;

  // Characters
  localparam logic [BYTE_W-1:0] ASCII_CR = 8'd13;
  localparam logic [BYTE_W-1:0] ASCII_LF = 8'd10;
  localparam logic [BYTE_W-1:0] ASCII_NUL = 8'd0;

  // Commands
  typedef enum logic [1:0] {
    CMD_BYTE = 2'd0,
    CMD_DROP = 2'd1,
    CMD_READ = 2'd2,
    CMD_NOP  = 2'd3
  } command_e;

  // One write to a buffer bank
  typedef struct packed {
    logic               we;
    logic [BANK_AW-1:0] addr;
    logic [BYTE_W-1:0]  data;
  } bank_wr_t;

  // Line state seen by the result path
  typedef struct packed {
    logic              front_valid;
    logic [OFFS_W-1:0] front_offset;
    logic [PEND_W-1:0] pending_count;
    logic [CTR_W-1:0]  buffer_overruns;
    logic [CTR_W-1:0]  table_overruns;
  } line_status_t;

  // Circular slot index: head plus k, wrapped at LINE_SLOTS (k < LINE_SLOTS)
  function automatic logic [SLOT_AW-1:0] slot_add(input logic [SLOT_AW-1:0] head,
                                                  input logic [COUNT_W-1:0] k);
    logic [COUNT_W:0] sum;
    sum = (COUNT_W+1)'(head) + (COUNT_W+1)'(k);
    if (sum >= (COUNT_W+1)'(LINE_SLOTS)) begin
      sum = sum - (COUNT_W+1)'(LINE_SLOTS);
    end
    return SLOT_AW'(sum);
  endfunction

endpackage

FILE: src/crlf_line_assembler_top.sv
// ----------------------------------------------------------------------------
// crlf_line_assembler_top
// CR LF line receive buffer: byte store in two banks, line queue, results.
// ----------------------------------------------------------------------------
// Takes one command beat per clock while in_stall_o is low (received byte,
// drop oldest line, or read buffer byte) and returns one result beat per
// command through the stage-1 and output registers. The line store is split
// into even and odd banks, each with one write port, so a byte and the CR
// fix-up next to it are written in the same cycle; the byte before the write
// position is kept in a register, so no store read sits in the byte path. A
// read command uses the banks' registered read port. The start-offset queue
// is circular, so a drop is a pointer move. The store needs no clearing after
// reset: a byte that was never written reads as an arbitrary value.
module crlf_line_assembler_top import crlfla_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        command_i,
  input  logic [BYTE_W-1:0] rx_byte_i,
  input  logic [BYTE_W-1:0] read_addr_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              front_valid_o,
  output logic [OFFS_W-1:0] front_offset_o,
  output logic [PEND_W-1:0] pending_count_o,
  output logic [BYTE_W-1:0] read_data_o,
  output logic [CTR_W-1:0]  buffer_overruns_o,
  output logic [CTR_W-1:0]  table_overruns_o
);

  command_e          cmd;
  logic              accept;
  logic              s1_adv;
  logic              s1_valid_q, s1_valid_d;
  logic              s1_read_q;
  logic              s1_bank_q;
  logic              out_valid_q, out_valid_d;
  line_status_t      status;
  line_status_t      out_status_q;
  logic [BYTE_W-1:0] out_rdata_q;
  bank_wr_t          wr_even, wr_odd;
  logic [BUF_AW-1:0] raddr;
  logic              rd_en, rd_in_range;
  logic [BYTE_W-1:0] rdata_even, rdata_odd, rdata_sel;

  assign cmd = command_e'(command_i);

  // Handshake
  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign accept     = in_valid_i && !in_stall_o;

  // Line state
  crlfla_line_ctrl u_line_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (accept),
    .command_i (cmd),
    .rx_byte_i (rx_byte_i),
    .wr_even_o (wr_even),
    .wr_odd_o  (wr_odd),
    .status_o  (status)
  );

  // Read address decode
  assign raddr       = BUF_AW'(read_addr_i);
  assign rd_in_range = (int'(read_addr_i) < BUF_BYTES);
  assign rd_en       = accept && (cmd == CMD_READ) && rd_in_range;

  // Line store banks
  crlfla_ram #(
    .DEPTH (BANK_DEPTH),
    .WIDTH (BYTE_W)
  ) u_bank_even (
    .clk_i   (clk_i),
    .we_i    (wr_even.we),
    .waddr_i (wr_even.addr),
    .wdata_i (wr_even.data),
    .re_i    (rd_en && !raddr[0]),
    .raddr_i (BANK_AW'(raddr >> 1)),
    .rdata_o (rdata_even)
  );

  crlfla_ram #(
    .DEPTH (BANK_DEPTH),
    .WIDTH (BYTE_W)
  ) u_bank_odd (
    .clk_i   (clk_i),
    .we_i    (wr_odd.we),
    .waddr_i (wr_odd.addr),
    .wdata_i (wr_odd.data),
    .re_i    (rd_en && raddr[0]),
    .raddr_i (BANK_AW'(raddr >> 1)),
    .rdata_o (rdata_odd)
  );

  assign rdata_sel = s1_bank_q ? rdata_odd : rdata_even;

  // Stage valids
  assign s1_valid_d  = accept || (s1_valid_q && !s1_adv);
  assign out_valid_d = s1_valid_q || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Stage 1: read in flight, state already updated
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_read_q <= rd_en;
      s1_bank_q <= raddr[0];
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_adv) begin
      out_status_q <= status;
      out_rdata_q  <= s1_read_q ? rdata_sel : '0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign front_valid_o     = out_status_q.front_valid;
  assign front_offset_o    = out_status_q.front_offset;
  assign pending_count_o   = out_status_q.pending_count;
  assign read_data_o       = out_rdata_q;
  assign buffer_overruns_o = out_status_q.buffer_overruns;
  assign table_overruns_o  = out_status_q.table_overruns;

endmodule

FILE: src/crlfla_ram.sv
// ----------------------------------------------------------------------------
// crlfla_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module crlfla_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 8,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/crlfla_line_ctrl.sv
// ----------------------------------------------------------------------------
// crlfla_line_ctrl
// Line state: write position, line start, last byte, start-offset queue and
// overrun counters. Issues the buffer writes for each received byte.
// ----------------------------------------------------------------------------
module crlfla_line_ctrl import crlfla_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  command_e          command_i,
  input  logic [BYTE_W-1:0] rx_byte_i,
  output bank_wr_t          wr_even_o,
  output bank_wr_t          wr_odd_o,
  output line_status_t      status_o
);

  logic [BUF_AW-1:0]  wp_q, wp_d;
  logic [BUF_AW-1:0]  ls_q, ls_d;
  logic [BYTE_W-1:0]  prev_q, prev_d;   // byte at wp_q - 1
  logic [COUNT_W-1:0] count_q, count_d;
  logic [SLOT_AW-1:0] head_q, head_d;
  logic [CTR_W-1:0]   bov_q, bov_d;
  logic [CTR_W-1:0]   tov_q, tov_d;
  logic [BUF_AW-1:0]  slots_q [LINE_SLOTS];

  logic               restart;
  logic [BUF_AW-1:0]  wp_eff, ls_eff, wpm1;
  logic               is_crlf, buf_full, tbl_full;
  logic               tbl_we;
  logic [SLOT_AW-1:0] tbl_slot;
  logic               sec_we;
  logic [BYTE_W-1:0]  sec_data;
  bank_wr_t           pri_wr, sec_wr;

  // Byte-path decode
  always_comb begin
    restart  = (wp_q == ls_q) && (count_q == '0);
    wp_eff   = restart ? '0 : wp_q;
    ls_eff   = restart ? '0 : ls_q;
    wpm1     = wp_eff - BUF_AW'(1);
    is_crlf  = (rx_byte_i == ASCII_LF) && (wp_eff != '0) && (prev_q == ASCII_CR);
    buf_full = (wp_eff == BUF_AW'(BUF_BYTES - 1));
    tbl_full = (count_q == COUNT_W'(LINE_SLOTS));
  end

  // Next state
  always_comb begin
    wp_d     = wp_q;
    ls_d     = ls_q;
    prev_d   = prev_q;
    count_d  = count_q;
    head_d   = head_q;
    bov_d    = bov_q;
    tov_d    = tov_q;
    tbl_we   = 1'b0;
    tbl_slot = slot_add(head_q, count_q);
    sec_we   = 1'b0;
    sec_data = ASCII_NUL;
    if (step_i) begin
      unique case (command_i)
        CMD_BYTE: begin
          ls_d = ls_eff;
          if (is_crlf) begin
            // CR becomes the terminator
            sec_we = 1'b1;
            prev_d = ASCII_NUL;
            if (wpm1 != ls_eff) begin
              tbl_we = 1'b1;
              if (tbl_full) begin
                tov_d    = tov_q + CTR_W'(1);
                tbl_slot = slot_add(head_q, COUNT_W'(LINE_SLOTS - 1));
              end else begin
                count_d = count_q + COUNT_W'(1);
              end
              ls_d = wp_eff;
              wp_d = wp_eff;
            end else begin
              // empty line, drop the pair
              wp_d = wpm1;
            end
          end else if (buf_full) begin
            // overwrite in place, plant a CR before it
            bov_d    = bov_q + CTR_W'(1);
            sec_we   = 1'b1;
            sec_data = ASCII_CR;
            prev_d   = ASCII_CR;
            wp_d     = wp_eff;
          end else begin
            prev_d = rx_byte_i;
            wp_d   = wp_eff + BUF_AW'(1);
          end
        end
        CMD_DROP: begin
          if (count_q != '0) begin
            head_d  = slot_add(head_q, COUNT_W'(1));
            count_d = count_q - COUNT_W'(1);
          end
        end
        CMD_READ: begin
        end
        CMD_NOP: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      ls_q    <= '0;
      prev_q  <= '0;
      count_q <= '0;
      head_q  <= '0;
      bov_q   <= '0;
      tov_q   <= '0;
    end else begin
      wp_q    <= wp_d;
      ls_q    <= ls_d;
      prev_q  <= prev_d;
      count_q <= count_d;
      head_q  <= head_d;
      bov_q   <= bov_d;
      tov_q   <= tov_d;
    end
  end

  // Start-offset queue (circular)
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      slots_q[tbl_slot] <= ls_eff;
    end
  end

  // Bank writes: the byte at wp_eff and the fix-up at wp_eff - 1 always
  // fall into different banks
  always_comb begin
    pri_wr.we   = step_i && (command_i == CMD_BYTE);
    pri_wr.addr = BANK_AW'(wp_eff >> 1);
    pri_wr.data = rx_byte_i;
    sec_wr.we   = pri_wr.we && sec_we;
    sec_wr.addr = BANK_AW'(wpm1 >> 1);
    sec_wr.data = sec_data;
    if (wp_eff[0]) begin
      wr_odd_o  = pri_wr;
      wr_even_o = sec_wr;
    end else begin
      wr_even_o = pri_wr;
      wr_odd_o  = sec_wr;
    end
  end

  // Status after the last step
  always_comb begin
    status_o.front_valid     = (count_q != '0);
    status_o.front_offset    = status_o.front_valid ? OFFS_W'(slots_q[head_q]) : '0;
    status_o.pending_count   = PEND_W'(count_q);
    status_o.buffer_overruns = bov_q;
    status_o.table_overruns  = tov_q;
  end

endmodule

FILE: src/crlfla_checker.sv
// ----------------------------------------------------------------------------
// crlfla_checker
// Port-level checks for the CR LF line assembler, bound to the top level.
// ----------------------------------------------------------------------------
module crlfla_checker import crlfla_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic [1:0]        command_i,
  input logic [BYTE_W-1:0] rx_byte_i,
  input logic [BYTE_W-1:0] read_addr_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic              front_valid_o,
  input logic [OFFS_W-1:0] front_offset_o,
  input logic [PEND_W-1:0] pending_count_o,
  input logic [BYTE_W-1:0] read_data_o,
  input logic [CTR_W-1:0]  buffer_overruns_o,
  input logic [CTR_W-1:0]  table_overruns_o
);

  // Front flag follows the pending count
  a_front_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (front_valid_o == (pending_count_o != '0)))
    else $error("front_valid disagrees with pending_count");

  // No pending line shows offset zero
  a_front_offset_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !front_valid_o) |-> (front_offset_o == '0))
    else $error("front_offset nonzero with no pending line");

  // Queue never holds more than its slots
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (int'(pending_count_o) <= LINE_SLOTS))
    else $error("pending_count above slot count");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(pending_count_o)
      && $stable(read_data_o) && $stable(buffer_overruns_o)
      && $stable(table_overruns_o) && $stable(front_offset_o)))
    else $error("stalled result beat changed");

endmodule

bind crlf_line_assembler_top crlfla_checker u_crlfla_checker (.*);
